// ===== sv/kdpc_pkg.sv =====
`default_nettype none
package kdpc_pkg;

   // Default number of keyboard keys; two mouse buttons follow them
   localparam int NUM_KEYS_DEF = 16;

   // Counter and register widths
   localparam int DEB_WIDTH   = 9;
   localparam int HOLD_WIDTH  = 16;
   localparam int LIMIT_WIDTH = 8;

   localparam logic [DEB_WIDTH-1:0]  DEB_MAX  = {DEB_WIDTH{1'b1}};
   localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {HOLD_WIDTH{1'b1}};

   // Control register port
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_LIMIT  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TICKS_SLOW = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TICKS_FAST = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TICKS_MID  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAST_KEY_MASK   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MID_KEY_MASK    = 3'd5;

   // Register reset values
   localparam logic [LIMIT_WIDTH-1:0] DEBOUNCE_LIMIT_RST  = 8'd30;
   localparam logic [HOLD_WIDTH-1:0]  HOLD_TICKS_SLOW_RST = 16'd300;
   localparam logic [HOLD_WIDTH-1:0]  HOLD_TICKS_FAST_RST = 16'd50;
   localparam logic [HOLD_WIDTH-1:0]  HOLD_TICKS_MID_RST  = 16'd150;

   // Per-button classification for one tick
   typedef struct packed {
      logic pressed;
      logic press;
      logic sdown;
      logic ldown;
      logic rel;
   } lane_flags_type;

endpackage
`default_nettype wire

// ===== sv/kdpc_if.sv =====
`default_nettype none
// Tick channel: raw key and mouse levels
interface kdpc_req_if #(
   parameter int NUM_KEYS = kdpc_pkg::NUM_KEYS_DEF
) ();
   logic                valid;
   logic                ready;
   logic [NUM_KEYS-1:0] key_bits;
   logic                btn_left;
   logic                btn_right;

   modport source (output valid, key_bits, btn_left, btn_right, input ready);
   modport sink   (input valid, key_bits, btn_left, btn_right, output ready);
endinterface

// Result channel: per-button masks
interface kdpc_rsp_if #(
   parameter int NUM_KEYS = kdpc_pkg::NUM_KEYS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [NUM_KEYS+1:0]   pressed_mask;
   logic [NUM_KEYS+1:0]   press_mask;
   logic [NUM_KEYS+1:0]   short_down_mask;
   logic [NUM_KEYS+1:0]   long_down_mask;
   logic [NUM_KEYS+1:0]   release_mask;

   modport source (output valid, pressed_mask, press_mask, short_down_mask,
                   long_down_mask, release_mask, input ready);
   modport sink   (input valid, pressed_mask, press_mask, short_down_mask,
                   long_down_mask, release_mask, output ready);
endinterface
`default_nettype wire

// ===== sv/kdpc_lane.sv =====
`default_nettype none
module kdpc_lane (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                raw,
   input  wire logic [kdpc_pkg::LIMIT_WIDTH-1:0]    debounce_limit,
   input  wire logic [kdpc_pkg::HOLD_WIDTH-1:0]     hold_ticks_slow,
   input  wire logic [kdpc_pkg::HOLD_WIDTH-1:0]     hold_ticks_fast,
   input  wire logic [kdpc_pkg::HOLD_WIDTH-1:0]     hold_ticks_mid,
   input  wire logic                                fast_sel,
   input  wire logic                                mid_sel,
   output kdpc_pkg::lane_flags_type                 flags
);

   logic [kdpc_pkg::DEB_WIDTH-1:0]  deb_ff, deb_in;
   logic [kdpc_pkg::HOLD_WIDTH-1:0] hold_ff, hold_in, hold_inc, threshold;
   logic                            held_ff, held_in;
   logic                            level;

   // Debounce counter: saturating count of consecutive high ticks
   always_comb begin
      if (!raw) begin
         deb_in = '0;
      end else if (deb_ff == kdpc_pkg::DEB_MAX) begin
         deb_in = deb_ff;
      end else begin
         deb_in = deb_ff + 1'b1;
      end
   end

   assign level = deb_in > {1'b0, debounce_limit};

   // Hold threshold; fast wins over mid
   always_comb begin
      if (fast_sel) begin
         threshold = hold_ticks_fast;
      end else if (mid_sel) begin
         threshold = hold_ticks_mid;
      end else begin
         threshold = hold_ticks_slow;
      end
   end

   assign hold_inc = (hold_ff == kdpc_pkg::HOLD_MAX) ? hold_ff : hold_ff + 1'b1;

   // Press tracker
   always_comb begin
      flags.pressed = level;
      flags.press   = level && !held_ff;
      flags.sdown   = level && held_ff && (hold_inc < threshold);
      flags.ldown   = level && held_ff && !(hold_inc < threshold);
      flags.rel     = !level && held_ff;
      held_in       = level;
      if (level && !held_ff) begin
         hold_in = '0;
      end else if (level) begin
         hold_in = hold_inc;
      end else begin
         hold_in = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff  <= '0;
         hold_ff <= '0;
         held_ff <= 1'b0;
      end else if (advance) begin
         deb_ff  <= deb_in;
         hold_ff <= hold_in;
         held_ff <= held_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/kdpc_merge.sv =====
`default_nettype none
module kdpc_merge #(
   parameter int NUM_KEYS = kdpc_pkg::NUM_KEYS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire kdpc_pkg::lane_flags_type lane_flags [NUM_KEYS+2],
   output logic                          take_ok,
   kdpc_rsp_if.source                    rsp_ch
);

   localparam int NUM_BUTTONS = NUM_KEYS + 2;

   logic [NUM_BUTTONS-1:0] pressed_in, press_in, sdown_in, ldown_in, rel_in;
   logic [NUM_BUTTONS-1:0] pressed_ff, press_ff, sdown_ff, ldown_ff, rel_ff;
   logic                   valid_ff;

   // Gather lane results into masks
   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         pressed_in[i] = lane_flags[i].pressed;
         press_in[i]   = lane_flags[i].press;
         sdown_in[i]   = lane_flags[i].sdown;
         ldown_in[i]   = lane_flags[i].ldown;
         rel_in[i]     = lane_flags[i].rel;
      end
   end

   // Output register: free, or emptying on this edge
   assign take_ok = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pressed_ff <= pressed_in;
         press_ff   <= press_in;
         sdown_ff   <= sdown_in;
         ldown_ff   <= ldown_in;
         rel_ff     <= rel_in;
      end
   end

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.pressed_mask    = pressed_ff;
   assign rsp_ch.press_mask      = press_ff;
   assign rsp_ch.short_down_mask = sdown_ff;
   assign rsp_ch.long_down_mask  = ldown_ff;
   assign rsp_ch.release_mask    = rel_ff;

endmodule
`default_nettype wire

// ===== sv/key_debounce_press_classifier.sv =====
`default_nettype none
// A tick's result is registered in the output register on the edge of the tick transfer.
// Throughput: one tick per cycle while the result side takes results; each button has
// its own lane that updates its debounce and hold counters, and the output register
// takes the next result on the edge at which the current one is transferred.
// Reset (synchronous, active high) clears all counters and held flags, loads
// the control registers with their defaults and empties the output register.
module key_debounce_press_classifier #(
   parameter int NUM_KEYS = kdpc_pkg::NUM_KEYS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   kdpc_req_if.sink                                  req_ch,
   kdpc_rsp_if.source                                rsp_ch,
   input  wire logic                                 csr_wr_en,
   input  wire logic [kdpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   // Wide enough for a hold threshold or a button mask
   input  wire logic [(kdpc_pkg::HOLD_WIDTH > NUM_KEYS + 2 ?
                       kdpc_pkg::HOLD_WIDTH : NUM_KEYS + 2)-1:0] csr_wdata
);

   localparam int NUM_BUTTONS = NUM_KEYS + 2;

   logic [kdpc_pkg::LIMIT_WIDTH-1:0] debounce_limit_ff;
   logic [kdpc_pkg::HOLD_WIDTH-1:0]  hold_slow_ff, hold_fast_ff, hold_mid_ff;
   logic [NUM_BUTTONS-1:0]           fast_mask_ff, mid_mask_ff;
   logic [NUM_BUTTONS-1:0]           raw_vec;
   logic                             advance, take_ok;
   kdpc_pkg::lane_flags_type         lane_flags [NUM_BUTTONS];

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_limit_ff <= kdpc_pkg::DEBOUNCE_LIMIT_RST;
         hold_slow_ff      <= kdpc_pkg::HOLD_TICKS_SLOW_RST;
         hold_fast_ff      <= kdpc_pkg::HOLD_TICKS_FAST_RST;
         hold_mid_ff       <= kdpc_pkg::HOLD_TICKS_MID_RST;
         fast_mask_ff      <= '0;
         mid_mask_ff       <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            kdpc_pkg::CSR_DEBOUNCE_LIMIT: begin
               debounce_limit_ff <= csr_wdata[kdpc_pkg::LIMIT_WIDTH-1:0];
            end
            kdpc_pkg::CSR_HOLD_TICKS_SLOW: begin
               hold_slow_ff <= csr_wdata[kdpc_pkg::HOLD_WIDTH-1:0];
            end
            kdpc_pkg::CSR_HOLD_TICKS_FAST: begin
               hold_fast_ff <= csr_wdata[kdpc_pkg::HOLD_WIDTH-1:0];
            end
            kdpc_pkg::CSR_HOLD_TICKS_MID: begin
               hold_mid_ff <= csr_wdata[kdpc_pkg::HOLD_WIDTH-1:0];
            end
            kdpc_pkg::CSR_FAST_KEY_MASK: begin
               fast_mask_ff <= csr_wdata[NUM_BUTTONS-1:0];
            end
            kdpc_pkg::CSR_MID_KEY_MASK: begin
               mid_mask_ff <= csr_wdata[NUM_BUTTONS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Handshake
   assign req_ch.ready = take_ok;
   assign advance      = req_ch.valid && take_ok;

   // Mouse buttons sit above the keys
   assign raw_vec = {req_ch.btn_right, req_ch.btn_left, req_ch.key_bits};

   // One lane per button
   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      kdpc_lane u_lane (
         .clock           (clock),
         .reset           (reset),
         .advance         (advance),
         .raw             (raw_vec[g]),
         .debounce_limit  (debounce_limit_ff),
         .hold_ticks_slow (hold_slow_ff),
         .hold_ticks_fast (hold_fast_ff),
         .hold_ticks_mid  (hold_mid_ff),
         .fast_sel        (fast_mask_ff[g]),
         .mid_sel         (mid_mask_ff[g]),
         .flags           (lane_flags[g])
      );
   end

   // Merge lanes into the result register
   kdpc_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .lane_flags (lane_flags),
      .take_ok    (take_ok),
      .rsp_ch     (rsp_ch)
   );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;

   localparam int NK          = kdpc_pkg::NUM_KEYS_DEF;
   localparam int NB          = kdpc_pkg::NUM_KEYS_DEF + 2;
   localparam int CYCLE_LIMIT = 50000;
   localparam int SHOW_LIMIT  = 10;
   localparam int HOLD_OFF    = 200;
   localparam int SETTLE      = 8;
   localparam int LONG_TICKS  = 280;

   // Indexes past the last register; writes there must change nothing
   localparam logic [kdpc_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [kdpc_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_HI = 3'd7;

   typedef struct packed {
      logic [NK-1:0] keys;
      logic          left;
      logic          right;
   } tick_type;

   typedef struct packed {
      logic [NB-1:0] pressed;
      logic [NB-1:0] press;
      logic [NB-1:0] sdown;
      logic [NB-1:0] ldown;
      logic [NB-1:0] rel;
   } masks_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 csr_wr_en;
   logic [kdpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [NB-1:0]                        csr_wdata;

   kdpc_req_if #(.NUM_KEYS(NK)) req_ch ();
   kdpc_rsp_if #(.NUM_KEYS(NK)) rsp_ch ();

   key_debounce_press_classifier #(.NUM_KEYS(NK)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the control registers
   logic [kdpc_pkg::LIMIT_WIDTH-1:0] cfg_deb_limit = kdpc_pkg::DEBOUNCE_LIMIT_RST;
   logic [kdpc_pkg::HOLD_WIDTH-1:0]  cfg_hold_slow = kdpc_pkg::HOLD_TICKS_SLOW_RST;
   logic [kdpc_pkg::HOLD_WIDTH-1:0]  cfg_hold_fast = kdpc_pkg::HOLD_TICKS_FAST_RST;
   logic [kdpc_pkg::HOLD_WIDTH-1:0]  cfg_hold_mid  = kdpc_pkg::HOLD_TICKS_MID_RST;
   logic [NB-1:0]                    cfg_fast_mask = '0;
   logic [NB-1:0]                    cfg_mid_mask  = '0;

   // Per-button state of the classifier
   logic [kdpc_pkg::DEB_WIDTH-1:0]  deb_cnt  [NB];
   logic [kdpc_pkg::HOLD_WIDTH-1:0] hold_cnt [NB];
   logic [NB-1:0]                   held_now;

   // Button level generator: each button toggles after a random run length
   bit gen_level [NB];
   int gen_run   [NB];

   tick_type  pending_ticks [$];
   masks_type expected_masks [$];

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic rsp_hold;
   logic req_fire;

   int cycle_count     = 0;
   int fail_count      = 0;
   int results_checked = 0;
   int ticks_taken     = 0;
   int press_seen      = 0;
   int short_seen      = 0;
   int long_seen       = 0;
   int release_seen    = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Work out the five masks for one tick and advance the shadow state
   function automatic masks_type classify_tick(input tick_type t);
      masks_type                       r;
      logic                            raw;
      logic                            lvl;
      logic [kdpc_pkg::HOLD_WIDTH-1:0] thr;
      int                              b;
      r = '0;
      for (b = 0; b < NB; b++) begin
         if (b < NK) raw = t.keys[b];
         else if (b == NK) raw = t.left;
         else raw = t.right;

         if (raw) begin
            if (deb_cnt[b] != kdpc_pkg::DEB_MAX) deb_cnt[b] = deb_cnt[b] + 1'b1;
         end else begin
            deb_cnt[b] = '0;
         end
         lvl = deb_cnt[b] > {1'b0, cfg_deb_limit};
         r.pressed[b] = lvl;

         // fast mask wins over mid mask
         if (cfg_fast_mask[b]) thr = cfg_hold_fast;
         else if (cfg_mid_mask[b]) thr = cfg_hold_mid;
         else thr = cfg_hold_slow;

         if (lvl && !held_now[b]) begin
            r.press[b]  = 1'b1;
            hold_cnt[b] = '0;
            held_now[b] = 1'b1;
         end else if (lvl && held_now[b]) begin
            if (hold_cnt[b] != kdpc_pkg::HOLD_MAX) hold_cnt[b] = hold_cnt[b] + 1'b1;
            if (hold_cnt[b] < thr) r.sdown[b] = 1'b1;
            else r.ldown[b] = 1'b1;
         end else if (!lvl && held_now[b]) begin
            r.rel[b]    = 1'b1;
            held_now[b] = 1'b0;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [NB-1:0] want,
                              input logic [NB-1:0] got);
      if (got !== want) begin
         if (fail_count < SHOW_LIMIT)
            $display("mismatch in %s, result %0d: expected %05h, got %05h",
                     name, results_checked, want, got);
         fail_count++;
      end
   endtask

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Monitor: predict on each tick transfer, check on each result transfer
   always @(posedge clock) begin : watch
      masks_type got;
      masks_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.pressed_mask, rsp_ch.press_mask, rsp_ch.short_down_mask,
                   rsp_ch.long_down_mask, rsp_ch.release_mask};
            if (expected_masks.size() == 0) begin
               if (fail_count < SHOW_LIMIT)
                  $display("result with nothing outstanding: pressed %05h", got.pressed);
               fail_count++;
            end else begin
               want = expected_masks.pop_front();
               check_field("pressed_mask", want.pressed, got.pressed);
               check_field("press_mask", want.press, got.press);
               check_field("short_down_mask", want.sdown, got.sdown);
               check_field("long_down_mask", want.ldown, got.ldown);
               check_field("release_mask", want.rel, got.rel);
               results_checked++;
               press_seen   += $countones(want.press);
               short_seen   += $countones(want.sdown);
               long_seen    += $countones(want.ldown);
               release_seen += $countones(want.rel);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_masks.push_back(classify_tick({req_ch.key_bits, req_ch.btn_left,
                                                    req_ch.btn_right}));
            ticks_taken++;
         end
      end
   end

   // Tick driver: holds an offered tick until its transfer
   always @(negedge clock) begin : drive_req
      tick_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_ticks.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.key_bits  <= nxt.keys;
            req_ch.btn_left  <= nxt.left;
            req_ch.btn_right <= nxt.right;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result sink with random stalls and an optional long hold-off
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic push_tick(input logic [NK-1:0] keys, input logic left,
                            input logic right);
      pending_ticks.push_back({keys, left, right});
   endtask

   // Mostly clean holds of random length with short bounces, some pure noise
   task automatic queue_random(input int count, input int max_run);
      tick_type      t;
      int            n;
      int            b;
      logic [NB-1:0] lv;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(99) < 5) begin
            t = NB'($urandom());
         end else begin
            for (b = 0; b < NB; b++) begin
               if (gen_run[b] == 0) begin
                  gen_level[b] = !gen_level[b];
                  gen_run[b]   = ($urandom_range(99) < 30) ? $urandom_range(1, 3)
                                                           : $urandom_range(1, max_run);
               end
               gen_run[b]--;
               lv[b] = gen_level[b];
            end
            t = {lv[NK-1:0], lv[NK], lv[NK+1]};
         end
         pending_ticks.push_back(t);
      end
   endtask

   task automatic write_reg(input logic [kdpc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [NB-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         kdpc_pkg::CSR_DEBOUNCE_LIMIT:  cfg_deb_limit = val[kdpc_pkg::LIMIT_WIDTH-1:0];
         kdpc_pkg::CSR_HOLD_TICKS_SLOW: cfg_hold_slow = val[kdpc_pkg::HOLD_WIDTH-1:0];
         kdpc_pkg::CSR_HOLD_TICKS_FAST: cfg_hold_fast = val[kdpc_pkg::HOLD_WIDTH-1:0];
         kdpc_pkg::CSR_HOLD_TICKS_MID:  cfg_hold_mid  = val[kdpc_pkg::HOLD_WIDTH-1:0];
         kdpc_pkg::CSR_FAST_KEY_MASK:   cfg_fast_mask = val;
         kdpc_pkg::CSR_MID_KEY_MASK:    cfg_mid_mask  = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   // Wait until every tick is taken and every result has come back
   task automatic wait_idle();
      while (pending_ticks.size() != 0 || req_ch.valid || expected_masks.size() != 0
             || rsp_hold)
         @(negedge clock);
   endtask

   initial begin
      int b;
      int n;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.key_bits  = '0;
      req_ch.btn_left  = 1'b0;
      req_ch.btn_right = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      rsp_hold         = 1'b0;
      held_now         = '0;
      for (b = 0; b < NB; b++) begin
         deb_cnt[b]   = '0;
         hold_cnt[b]  = '0;
         gen_level[b] = 1'b0;
         gen_run[b]   = 1;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: instant debounce, zero fast threshold, overlapping masks;
      // slow threshold left at its reset value
      write_reg(kdpc_pkg::CSR_DEBOUNCE_LIMIT, 18'd0);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_FAST, 18'd0);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_MID, 18'd1);
      write_reg(kdpc_pkg::CSR_FAST_KEY_MASK, 18'h2_000F);
      write_reg(kdpc_pkg::CSR_MID_KEY_MASK, 18'h1_00FC);
      push_tick(16'h0000, 1'b0, 1'b0);
      push_tick(16'hFFFF, 1'b1, 1'b1);
      push_tick(16'hFFFF, 1'b1, 1'b1);
      push_tick(16'hFFFF, 1'b1, 1'b1);
      push_tick(16'h5555, 1'b1, 1'b0);
      push_tick(16'hAAAA, 1'b0, 1'b1);
      push_tick(16'hAAAA, 1'b0, 1'b1);
      push_tick(16'h0000, 1'b0, 1'b0);
      push_tick(16'h0000, 1'b0, 1'b0);
      push_tick(16'h0001, 1'b0, 1'b0);
      push_tick(16'h0002, 1'b0, 1'b0);
      push_tick(16'h8000, 1'b0, 1'b0);
      push_tick(16'h0000, 1'b0, 1'b0);
      push_tick(16'h0000, 1'b1, 1'b0);
      push_tick(16'h0000, 1'b0, 1'b1);
      push_tick(16'hFFFF, 1'b1, 1'b1);
      push_tick(16'h0000, 1'b0, 1'b0);
      push_tick(16'h00FF, 1'b0, 1'b0);
      push_tick(16'hFF00, 1'b0, 1'b0);
      push_tick(16'h0000, 1'b0, 1'b0);
      wait_idle();

      // Near-default timing with long holds, no idling
      write_reg(kdpc_pkg::CSR_DEBOUNCE_LIMIT, 18'd30);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_FAST, 18'd50);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_MID, 18'd150);
      write_reg(kdpc_pkg::CSR_FAST_KEY_MASK, NB'($urandom()));
      write_reg(kdpc_pkg::CSR_MID_KEY_MASK, NB'($urandom()));
      queue_random(120, 120);
      wait_idle();

      // Short thresholds, sender mostly idle
      write_reg(kdpc_pkg::CSR_DEBOUNCE_LIMIT, 18'd2);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_SLOW, 18'd6);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_FAST, 18'd3);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_MID, 18'd4);
      write_reg(kdpc_pkg::CSR_FAST_KEY_MASK, NB'($urandom()));
      write_reg(kdpc_pkg::CSR_MID_KEY_MASK, NB'($urandom()));
      set_idling(79, 0);
      queue_random(100, 14);
      wait_idle();

      // No debounce, every button fast, receiver mostly stalled
      set_idling(0, 0);
      write_reg(kdpc_pkg::CSR_DEBOUNCE_LIMIT, 18'd0);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_SLOW, 18'd1);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_FAST, 18'd2);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_MID, 18'd0);
      write_reg(kdpc_pkg::CSR_FAST_KEY_MASK, 18'h3_FFFF);
      write_reg(kdpc_pkg::CSR_MID_KEY_MASK, NB'($urandom()));
      set_idling(0, 79);
      queue_random(100, 6);
      wait_idle();

      // Zero fast threshold, mid never reaches long-down, both sides idling
      set_idling(0, 0);
      write_reg(kdpc_pkg::CSR_DEBOUNCE_LIMIT, 18'd5);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_SLOW, 18'd10);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_FAST, 18'd0);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_MID, 18'd65535);
      write_reg(kdpc_pkg::CSR_FAST_KEY_MASK, NB'($urandom()));
      write_reg(kdpc_pkg::CSR_MID_KEY_MASK, 18'h3_FFFF);
      set_idling(27, 27);
      queue_random(100, 25);
      wait_idle();

      // Back-pressure: result side held off while ticks keep coming
      set_idling(0, 0);
      @(negedge clock);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_OFF) @(negedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      queue_random(40, 25);
      wait_idle();

      // Unmapped indexes must leave the registers alone
      write_reg(CSR_UNMAPPED_LO, 18'h3_FFFF);
      write_reg(CSR_UNMAPPED_HI, 18'h0_0000);

      // Longest debounce limit, then a hold that runs past some thresholds
      write_reg(kdpc_pkg::CSR_DEBOUNCE_LIMIT, 18'd255);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_SLOW, 18'd1);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_FAST, 18'd65535);
      write_reg(kdpc_pkg::CSR_HOLD_TICKS_MID, 18'd20);
      write_reg(kdpc_pkg::CSR_FAST_KEY_MASK, 18'h1_000F);
      write_reg(kdpc_pkg::CSR_MID_KEY_MASK, 18'h2_00FF);
      for (n = 0; n < 3; n++) push_tick(16'h0000, 1'b0, 1'b0);
      for (n = 0; n < LONG_TICKS; n++) push_tick(16'hFFFF, 1'b1, 1'b1);
      for (n = 0; n < 3; n++) push_tick(16'h0000, 1'b0, 1'b0);
      wait_idle();

      repeat (SETTLE) @(negedge clock);
      if (expected_masks.size() != 0) begin
         $display("%0d results never arrived", expected_masks.size());
         fail_count++;
      end
      $display("ran %0d ticks under several register settings and idling mixes, %0d checked",
               ticks_taken, results_checked);
      $display("button events: %0d press, %0d short-down, %0d long-down, %0d release",
               press_seen, short_seen, long_seen, release_seen);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
